@@ sv/blr_pkg.sv @@
// Shared constants, types and helpers of the Bresenham line rasterizer.
`default_nettype none

package blr_pkg;

    localparam int COORD_BITS     = 14;
    localparam int DIFF_BITS      = COORD_BITS + 1;
    localparam int ERR_BITS       = COORD_BITS + 2;
    localparam int DIM_BITS       = 13;
    localparam int MAX_DIMENSION  = 4096;
    localparam int INDEX_BITS     = 24;
    localparam int COLOR_BITS     = 32;
    localparam int PROD_BITS      = 2 * DIM_BITS;
    localparam int IN_DATA_BITS   = 88;
    localparam int OUT_DATA_BITS  = 88;
    localparam int CFG_INDEX_BITS = 1;

    // Item kinds carried on the input tuser.
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [DIM_BITS-1:0] RESET_FRAME_WIDTH  = 13'd1000;
    localparam logic [DIM_BITS-1:0] RESET_FRAME_HEIGHT = 13'd640;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // Decoded item with the line setup already worked out for a start.
    typedef struct packed {
        logic                         op;
        coord_t                       start_x;
        coord_t                       start_y;
        coord_t                       target_x;
        coord_t                       target_y;
        logic [COORD_BITS-1:0]        span_x;
        logic signed [DIFF_BITS-1:0]  span_y_neg;
        logic                         dir_x;
        logic                         dir_y;
        logic signed [ERR_BITS-1:0]   err_init;
        logic [COLOR_BITS-1:0]        color;
    } cmd_t;

    // Pixel handed from the step engine to the pixel stage.
    typedef struct packed {
        coord_t                x;
        coord_t                y;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
    } pix_t;

    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
        logic [DIM_BITS-1:0] lim;
        lim = DIM_BITS'(MAX_DIMENSION);
        return (v > lim) ? lim : v;
    endfunction

endpackage

`default_nettype wire

@@ sv/blr_front.sv @@
// Front end: decodes input items and computes the line setup for start items.
`default_nettype none

module blr_front (
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // s_tdata: start_x, start_y, end_x, end_y, line_color (lowest bit first)
    input  wire logic [blr_pkg::IN_DATA_BITS-1:0]    s_tdata,
    // s_tuser: operation
    input  wire logic                                s_tuser,
    input  wire logic                                q_full,
    output logic                                     q_push,
    output blr_pkg::cmd_t                            q_cmd
);

    blr_pkg::coord_t sx;
    blr_pkg::coord_t sy;
    blr_pkg::coord_t ex;
    blr_pkg::coord_t ey;
    logic signed [blr_pkg::DIFF_BITS-1:0] dx;
    logic signed [blr_pkg::DIFF_BITS-1:0] dy;
    logic signed [blr_pkg::DIFF_BITS-1:0] dx_neg;
    logic signed [blr_pkg::DIFF_BITS-1:0] dy_neg;
    logic [blr_pkg::COORD_BITS-1:0]       span_x;
    logic signed [blr_pkg::DIFF_BITS-1:0] span_y_neg;

    assign sx = blr_pkg::coord_t'(s_tdata[13:0]);
    assign sy = blr_pkg::coord_t'(s_tdata[27:14]);
    assign ex = blr_pkg::coord_t'(s_tdata[41:28]);
    assign ey = blr_pkg::coord_t'(s_tdata[55:42]);

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb
    begin
        dx     = {ex[blr_pkg::COORD_BITS-1], ex} - {sx[blr_pkg::COORD_BITS-1], sx};
        dy     = {ey[blr_pkg::COORD_BITS-1], ey} - {sy[blr_pkg::COORD_BITS-1], sy};
        dx_neg = -dx;
        dy_neg = -dy;
        span_x = dx[blr_pkg::DIFF_BITS-1] ? dx_neg[blr_pkg::COORD_BITS-1:0]
                                          : dx[blr_pkg::COORD_BITS-1:0];
        span_y_neg = dy[blr_pkg::DIFF_BITS-1] ? dy : dy_neg;

        q_cmd.op         = s_tuser;
        q_cmd.start_x    = sx;
        q_cmd.start_y    = sy;
        q_cmd.target_x   = ex;
        q_cmd.target_y   = ey;
        q_cmd.span_x     = span_x;
        q_cmd.span_y_neg = span_y_neg;
        q_cmd.dir_x      = sx < ex;
        q_cmd.dir_y      = sy < ey;
        q_cmd.err_init   = {2'b00, span_x}
                         + {span_y_neg[blr_pkg::DIFF_BITS-1], span_y_neg};
        q_cmd.color      = s_tdata[87:56];
    end

endmodule

`default_nettype wire

@@ sv/blr_queue.sv @@
// Two-entry queue of decoded items between the front end and the step engine.
`default_nettype none

module blr_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire blr_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output logic               full,
    output logic               not_empty,
    output blr_pkg::cmd_t      head_cmd
);

    blr_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ sv/blr_step.sv @@
// Step engine: holds the line state and runs one Bresenham step per advance item.
`default_nettype none

module blr_step (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire blr_pkg::cmd_t q_cmd,
    output logic               q_pop,
    output logic               pix_valid,
    input  wire logic          pix_ready,
    output blr_pkg::pix_t      pix
);

    blr_pkg::coord_t                      cursor_x_reg;
    blr_pkg::coord_t                      cursor_x_next;
    blr_pkg::coord_t                      cursor_y_reg;
    blr_pkg::coord_t                      cursor_y_next;
    blr_pkg::coord_t                      target_x_reg;
    blr_pkg::coord_t                      target_x_next;
    blr_pkg::coord_t                      target_y_reg;
    blr_pkg::coord_t                      target_y_next;
    logic [blr_pkg::COORD_BITS-1:0]       span_x_reg;
    logic [blr_pkg::COORD_BITS-1:0]       span_x_next;
    logic signed [blr_pkg::DIFF_BITS-1:0] span_y_neg_reg;
    logic signed [blr_pkg::DIFF_BITS-1:0] span_y_neg_next;
    logic                                 dir_x_reg;
    logic                                 dir_x_next;
    logic                                 dir_y_reg;
    logic                                 dir_y_next;
    logic signed [blr_pkg::ERR_BITS-1:0]  err_reg;
    logic signed [blr_pkg::ERR_BITS-1:0]  err_next;
    logic [blr_pkg::COLOR_BITS-1:0]       color_reg;
    logic [blr_pkg::COLOR_BITS-1:0]       color_next;
    logic                                 active_reg;
    logic                                 active_next;
    logic                                 valid_reg;
    logic                                 valid_next;

    logic                                 is_start;
    logic                                 stage_ready;
    logic                                 produce;
    logic signed [blr_pkg::ERR_BITS:0]    doubled;
    logic signed [blr_pkg::ERR_BITS:0]    syn_ext;
    logic signed [blr_pkg::ERR_BITS:0]    sx_ext;
    logic                                 step_x;
    logic                                 step_y;
    blr_pkg::coord_t                      x_adv;
    blr_pkg::coord_t                      y_adv;
    logic signed [blr_pkg::ERR_BITS-1:0]  err_adv;

    assign is_start    = q_cmd.op == blr_pkg::OP_START;
    assign stage_ready = !valid_reg || pix_ready;
    // An advance item with no line in progress is consumed without a pixel.
    assign q_pop       = q_valid && (stage_ready || (!is_start && !active_reg));
    assign produce     = q_pop && (is_start || active_reg);

    assign pix_valid = valid_reg;
    assign pix.x     = cursor_x_reg;
    assign pix.y     = cursor_y_reg;
    assign pix.color = color_reg;
    assign pix.last  = !active_reg;

    always_comb
    begin
        doubled = {err_reg, 1'b0};
        syn_ext = {{2{span_y_neg_reg[blr_pkg::DIFF_BITS-1]}}, span_y_neg_reg};
        sx_ext  = {3'b000, span_x_reg};
        step_x  = doubled >= syn_ext;
        step_y  = doubled <= sx_ext;
        x_adv   = cursor_x_reg;
        y_adv   = cursor_y_reg;
        err_adv = err_reg;
        if (step_x)
        begin
            err_adv = err_adv + {span_y_neg_reg[blr_pkg::DIFF_BITS-1], span_y_neg_reg};
            x_adv   = dir_x_reg ? cursor_x_reg + 14'sd1 : cursor_x_reg - 14'sd1;
        end
        if (step_y)
        begin
            err_adv = err_adv + {2'b00, span_x_reg};
            y_adv   = dir_y_reg ? cursor_y_reg + 14'sd1 : cursor_y_reg - 14'sd1;
        end
    end

    always_comb
    begin
        cursor_x_next   = cursor_x_reg;
        cursor_y_next   = cursor_y_reg;
        target_x_next   = target_x_reg;
        target_y_next   = target_y_reg;
        span_x_next     = span_x_reg;
        span_y_neg_next = span_y_neg_reg;
        dir_x_next      = dir_x_reg;
        dir_y_next      = dir_y_reg;
        err_next        = err_reg;
        color_next      = color_reg;
        active_next     = active_reg;
        valid_next      = valid_reg && !pix_ready;
        if (produce)
        begin
            valid_next = 1'b1;
            if (is_start)
            begin
                cursor_x_next   = q_cmd.start_x;
                cursor_y_next   = q_cmd.start_y;
                target_x_next   = q_cmd.target_x;
                target_y_next   = q_cmd.target_y;
                span_x_next     = q_cmd.span_x;
                span_y_neg_next = q_cmd.span_y_neg;
                dir_x_next      = q_cmd.dir_x;
                dir_y_next      = q_cmd.dir_y;
                err_next        = q_cmd.err_init;
                color_next      = q_cmd.color;
                active_next     = !(q_cmd.start_x == q_cmd.target_x &&
                                    q_cmd.start_y == q_cmd.target_y);
            end
            else
            begin
                cursor_x_next = x_adv;
                cursor_y_next = y_adv;
                err_next      = err_adv;
                active_next   = !(x_adv == target_x_reg && y_adv == target_y_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
            target_x_reg   <= '0;
            target_y_reg   <= '0;
            span_x_reg     <= '0;
            span_y_neg_reg <= '0;
            dir_x_reg      <= 1'b0;
            dir_y_reg      <= 1'b0;
            err_reg        <= '0;
            color_reg      <= '0;
            active_reg     <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            cursor_x_reg   <= cursor_x_next;
            cursor_y_reg   <= cursor_y_next;
            target_x_reg   <= target_x_next;
            target_y_reg   <= target_y_next;
            span_x_reg     <= span_x_next;
            span_y_neg_reg <= span_y_neg_next;
            dir_x_reg      <= dir_x_next;
            dir_y_reg      <= dir_y_next;
            err_reg        <= err_next;
            color_reg      <= color_next;
            active_reg     <= active_next;
            valid_reg      <= valid_next;
        end
    end

`ifndef SYNTHESIS
    // A start item always yields a pixel in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && is_start |=> valid_reg)
        else $error("start item produced no pixel");

    // An advance with no line in progress leaves the cursor alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && !is_start && !active_reg |=>
            cursor_x_reg == $past(cursor_x_reg) && cursor_y_reg == $past(cursor_y_reg))
        else $error("idle advance moved the cursor");

    // A line in progress has not yet reached its endpoint.
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> !(cursor_x_reg == target_x_reg && cursor_y_reg == target_y_reg))
        else $error("line still active at its endpoint");
`endif

endmodule

`default_nettype wire

@@ sv/blr_pixel.sv @@
// Pixel stage: frame registers, clipping, index multiply and the output register.
`default_nettype none

module blr_pixel (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [blr_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [blr_pkg::DIM_BITS-1:0]           cfg_data,
    input  wire logic                                   pix_valid,
    output logic                                        pix_ready,
    input  wire blr_pkg::pix_t                          pix,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [blr_pkg::OUT_DATA_BITS-1:0]           m_tdata,
    output logic                                        m_tlast
);

    logic [blr_pkg::DIM_BITS-1:0]   width_reg;
    logic [blr_pkg::DIM_BITS-1:0]   width_next;
    logic [blr_pkg::DIM_BITS-1:0]   height_reg;
    logic [blr_pkg::DIM_BITS-1:0]   height_next;

    logic                           p1_valid_reg;
    logic                           p1_valid_next;
    blr_pkg::pix_t                  p1_pix_reg;
    logic                           p1_inside_reg;
    logic [blr_pkg::PROD_BITS-1:0]  p1_prod_reg;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    blr_pkg::pix_t                  out_pix_reg;
    logic                           out_inside_reg;
    logic [blr_pkg::INDEX_BITS-1:0] out_index_reg;

    logic                           out_ready;
    logic                           p1_ready;
    logic                           p1_load;
    logic                           out_load;
    logic                           in_frame;
    logic [blr_pkg::PROD_BITS-1:0]  prod;
    logic [blr_pkg::INDEX_BITS-1:0] index;

    assign out_ready = !out_valid_reg || m_tready;
    assign p1_ready  = !p1_valid_reg || out_ready;
    assign pix_ready = p1_ready;
    assign p1_load   = pix_valid && p1_ready;
    assign out_load  = p1_valid_reg && out_ready;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                blr_pkg::REG_FRAME_WIDTH:  width_next  = blr_pkg::clamp_dim(cfg_data);
                blr_pkg::REG_FRAME_HEIGHT: height_next = blr_pkg::clamp_dim(cfg_data);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        in_frame = !pix.x[blr_pkg::COORD_BITS-1] && !pix.y[blr_pkg::COORD_BITS-1]
                && (pix.x[blr_pkg::DIM_BITS-1:0] < width_reg)
                && (pix.y[blr_pkg::DIM_BITS-1:0] < height_reg);
        prod   = blr_pkg::PROD_BITS'(pix.y[blr_pkg::DIM_BITS-1:0])
               * blr_pkg::PROD_BITS'(width_reg);
        index  = p1_inside_reg
               ? p1_prod_reg[blr_pkg::INDEX_BITS-1:0]
                 + blr_pkg::INDEX_BITS'(p1_pix_reg.x[blr_pkg::DIM_BITS-1:0])
               : '0;
        p1_valid_next  = p1_load || (p1_valid_reg && !out_ready);
        out_valid_next = out_load || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= blr_pkg::RESET_FRAME_WIDTH;
            height_reg    <= blr_pkg::RESET_FRAME_HEIGHT;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_load)
        begin
            p1_pix_reg    <= pix;
            p1_inside_reg <= in_frame;
            p1_prod_reg   <= prod;
        end
        if (out_load)
        begin
            out_pix_reg    <= p1_pix_reg;
            out_inside_reg <= p1_inside_reg;
            out_index_reg  <= index;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_pix_reg.last;
    assign m_tdata  = {3'b000, out_inside_reg, out_pix_reg.color, out_index_reg,
                       out_pix_reg.y, out_pix_reg.x};

endmodule

`default_nettype wire

@@ sv/bresenham_line_raster_top.sv @@
// Top level of the Bresenham line rasterizer.
//
// Channel   Direction  Handshake          Contents
// s_*       in         tvalid/tready      tuser operation, tdata endpoints and color
// m_*       out        tvalid/tready      tdata pixel fields, tlast at the line endpoint
// cfg_*     in         cfg_we             frame_width (index 0), frame_height (index 1)
//
// Sustained rate is one item per clock while m_tready stays high; after its item is
// accepted, each pixel passes the queue, step, index multiply and output registers.
// The step engine updates the error term and cursor once per item.
// Reset idles the line, empties the queue and loads a frame of 1000 by 640.
// A stall on m_tready backs up the pixel stages; the two-entry queue keeps s_tready
// independent of it until the queue fills.
`default_nettype none

module bresenham_line_raster_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [blr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [blr_pkg::DIM_BITS-1:0]        cfg_data,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // s_tdata: start_x, start_y, end_x, end_y, line_color (lowest bit first)
    input  wire logic [blr_pkg::IN_DATA_BITS-1:0]    s_tdata,
    // s_tuser: operation
    input  wire logic                                s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // m_tdata: pixel_x, pixel_y, pixel_index, pixel_color, write_enable, zero pad
    output logic [blr_pkg::OUT_DATA_BITS-1:0]        m_tdata,
    output logic                                     m_tlast
);

    logic          q_full;
    logic          q_push;
    blr_pkg::cmd_t q_push_cmd;
    logic          q_pop;
    logic          q_not_empty;
    blr_pkg::cmd_t q_head;
    logic          pix_valid;
    logic          pix_ready;
    blr_pkg::pix_t pix;

    blr_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_push_cmd)
    );

    blr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_cmd  (q_head)
    );

    blr_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_cmd     (q_head),
        .q_pop     (q_pop),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix)
    );

    blr_pixel u_pixel (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the Bresenham line rasterizer: directed and random lines against a predictor.
`default_nettype none

module tb_top;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 75;

    typedef struct {
        logic                             op;
        logic [blr_pkg::IN_DATA_BITS-1:0] data;
    } line_cmd_t;

    typedef struct {
        blr_pkg::coord_t                x;
        blr_pkg::coord_t                y;
        logic [blr_pkg::INDEX_BITS-1:0] index;
        logic [blr_pkg::COLOR_BITS-1:0] color;
        logic                           we;
        logic                           last;
    } pixel_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_we = 1'b0;
    logic [blr_pkg::CFG_INDEX_BITS-1:0] cfg_index = blr_pkg::REG_FRAME_WIDTH;
    logic [blr_pkg::DIM_BITS-1:0]       cfg_data = '0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [blr_pkg::IN_DATA_BITS-1:0]   s_tdata = '0;
    logic                               s_tuser = blr_pkg::OP_ADVANCE;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [blr_pkg::OUT_DATA_BITS-1:0]  m_tdata;
    logic                               m_tlast;

    bresenham_line_raster_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    line_cmd_t line_cmds[$];
    pixel_t    pending_pixels[$];
    line_cmd_t next_cmd;
    int        mismatches = 0;
    int        cycle_count = 0;
    int        hold_off = 0;
    int        stall_left = 0;
    bit        tx_steady = 1'b0;
    bit        rx_steady = 1'b0;

    // Predictor state, mirrors the line engine.
    blr_pkg::coord_t                      at_x = '0;
    blr_pkg::coord_t                      at_y = '0;
    blr_pkg::coord_t                      goal_x = '0;
    blr_pkg::coord_t                      goal_y = '0;
    logic [blr_pkg::COORD_BITS-1:0]       run_x = '0;
    logic signed [blr_pkg::DIFF_BITS-1:0] run_y_neg = '0;
    logic                                 up_x = 1'b0;
    logic                                 up_y = 1'b0;
    logic signed [blr_pkg::ERR_BITS-1:0]  err_acc = '0;
    logic [blr_pkg::COLOR_BITS-1:0]       ink = '0;
    bit                                   drawing = 1'b0;
    logic [blr_pkg::DIM_BITS-1:0]         frame_w = blr_pkg::RESET_FRAME_WIDTH;
    logic [blr_pkg::DIM_BITS-1:0]         frame_h = blr_pkg::RESET_FRAME_HEIGHT;

    // Frame size seen by the stimulus generator.
    int gen_w = 1000;
    int gen_h = 640;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic int fit_coord(int v);
        if (v < -8192)
            return -8192;
        else if (v > 8191)
            return 8191;
        else
            return v;
    endfunction

    function automatic int iabs(int v);
        return (v < 0) ? -v : v;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d, expected %0d (cycle %0d)",
                 what, got, want, cycle_count);
        mismatches++;
    endtask

    // Works out the pixel that one accepted item causes, if any.
    task automatic step_line(logic op, logic [blr_pkg::IN_DATA_BITS-1:0] d);
        int     dx;
        int     dy;
        int     doubled;
        int     w;
        int     h;
        int     px;
        int     py;
        bit     emit;
        pixel_t pix;
        emit = 1'b1;
        if (op == blr_pkg::OP_START)
        begin
            at_x   = d[13:0];
            at_y   = d[27:14];
            goal_x = d[41:28];
            goal_y = d[55:42];
            ink    = d[87:56];
            dx = int'(goal_x) - int'(at_x);
            dy = int'(goal_y) - int'(at_y);
            run_x     = blr_pkg::COORD_BITS'(iabs(dx));
            run_y_neg = blr_pkg::DIFF_BITS'(-iabs(dy));
            up_x = at_x < goal_x;
            up_y = at_y < goal_y;
            err_acc = $signed({2'b00, run_x}) + run_y_neg;
        end
        else if (!drawing)
        begin
            emit = 1'b0;
        end
        else
        begin
            doubled = 2 * int'(err_acc);
            if (doubled >= int'(run_y_neg))
            begin
                err_acc = err_acc + run_y_neg;
                at_x = at_x + (up_x ? 14'sd1 : -14'sd1);
            end
            if (doubled <= int'(run_x))
            begin
                err_acc = err_acc + $signed({2'b00, run_x});
                at_y = at_y + (up_y ? 14'sd1 : -14'sd1);
            end
        end
        if (emit)
        begin
            w = (frame_w > blr_pkg::MAX_DIMENSION) ? blr_pkg::MAX_DIMENSION
                                                   : int'(frame_w);
            h = (frame_h > blr_pkg::MAX_DIMENSION) ? blr_pkg::MAX_DIMENSION
                                                   : int'(frame_h);
            px = int'(at_x);
            py = int'(at_y);
            pix.x     = at_x;
            pix.y     = at_y;
            pix.color = ink;
            pix.we    = px >= 0 && py >= 0 && px < w && py < h;
            pix.index = pix.we ? blr_pkg::INDEX_BITS'(py * w + px) : '0;
            pix.last  = at_x == goal_x && at_y == goal_y;
            drawing   = !pix.last;
            pending_pixels.push_back(pix);
        end
    endtask

    task automatic push_start(int sx, int sy, int ex, int ey,
                              logic [blr_pkg::COLOR_BITS-1:0] color);
        line_cmd_t c;
        c.op   = blr_pkg::OP_START;
        c.data = {color, 14'(ey), 14'(ex), 14'(sy), 14'(sx)};
        line_cmds.push_back(c);
    endtask

    task automatic push_advances(int n);
        line_cmd_t c;
        repeat (n)
        begin
            // The endpoint fields are ignored on an advance; fill them with noise anyway.
            c.op   = blr_pkg::OP_ADVANCE;
            c.data = {$urandom, $urandom, 24'($urandom)};
            line_cmds.push_back(c);
        end
    endtask

    // Queues one random line; returns the number of items that cause a pixel.
    task automatic queue_random_line(output int useful);
        int sx;
        int sy;
        int ex;
        int ey;
        int reach;
        int steps;
        int r;
        int wx;
        int hy;
        wx = (gen_w > blr_pkg::MAX_DIMENSION) ? blr_pkg::MAX_DIMENSION : gen_w;
        hy = (gen_h > blr_pkg::MAX_DIMENSION) ? blr_pkg::MAX_DIMENSION : gen_h;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            // Long line across the whole coordinate range, cut short by the next start.
            sx = int'($urandom_range(0, 16383)) - 8192;
            sy = int'($urandom_range(0, 16383)) - 8192;
            ex = int'($urandom_range(0, 16383)) - 8192;
            ey = int'($urandom_range(0, 16383)) - 8192;
            steps = $urandom_range(0, 6);
            push_start(sx, sy, ex, ey, $urandom);
            push_advances(steps);
            useful = 1 + steps;
        end
        else
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                sx = int'($urandom_range(0, wx + 16)) - 8;
                sy = int'($urandom_range(0, hy + 16)) - 8;
            end
            else
            begin
                sx = int'($urandom_range(0, 16383)) - 8192;
                sy = int'($urandom_range(0, 16383)) - 8192;
            end
            r = $urandom_range(0, 99);
            reach = (r < 80) ? 24 : (r < 95) ? 150 : 600;
            ex = fit_coord(sx + int'($urandom_range(0, 2 * reach)) - reach);
            ey = fit_coord(sy + int'($urandom_range(0, 2 * reach)) - reach);
            steps = iabs(ex - sx) > iabs(ey - sy) ? iabs(ex - sx) : iabs(ey - sy);
            push_start(sx, sy, ex, ey, $urandom);
            push_advances(steps);
            useful = 1 + steps;
            if ($urandom_range(0, 99) < 15)
                push_advances($urandom_range(1, 3));
        end
    endtask

    task automatic set_frame(int w, int h);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= blr_pkg::REG_FRAME_WIDTH;
        cfg_data  <= blr_pkg::DIM_BITS'(w);
        @(posedge clk);
        cfg_index <= blr_pkg::REG_FRAME_HEIGHT;
        cfg_data  <= blr_pkg::DIM_BITS'(h);
        @(posedge clk);
        cfg_we <= 1'b0;
        gen_w = w;
        gen_h = h;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (line_cmds.size() != 0 || s_tvalid || pending_pixels.size() != 0)
            @(negedge clk);
        // Trailing advances may still be in the pipeline without a pixel to show for it.
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Driver: presents queued items, with random gaps between them unless tx_steady is set.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tuser  <= blr_pkg::OP_ADVANCE;
            s_tdata  <= '0;
            hold_off = 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (hold_off > 0)
            begin
                hold_off--;
                s_tvalid <= 1'b0;
            end
            else if (line_cmds.size() > 0)
            begin
                next_cmd = line_cmds.pop_front();
                s_tuser  <= next_cmd.op;
                s_tdata  <= next_cmd.data;
                s_tvalid <= 1'b1;
                hold_off = tx_steady ? 0 : pick_gap();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Predictor: follows register writes and accepted input items.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    blr_pkg::REG_FRAME_WIDTH:  frame_w = cfg_data;
                    blr_pkg::REG_FRAME_HEIGHT: frame_h = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                step_line(s_tuser, s_tdata);
        end
    end

    // Monitor: checks each accepted pixel and throttles m_tready.
    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    report_mismatch("unexpected pixel, x", $signed(m_tdata[13:0]), 0);
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (m_tdata[13:0] !== want.x)
                        report_mismatch("pixel_x", $signed(m_tdata[13:0]), want.x);
                    if (m_tdata[27:14] !== want.y)
                        report_mismatch("pixel_y", $signed(m_tdata[27:14]), want.y);
                    if (m_tdata[51:28] !== want.index)
                        report_mismatch("pixel_index", m_tdata[51:28], want.index);
                    if (m_tdata[83:52] !== want.color)
                        report_mismatch("pixel_color", m_tdata[83:52], want.color);
                    if (m_tdata[84] !== want.we)
                        report_mismatch("write_enable", m_tdata[84], want.we);
                    if (m_tlast !== want.last)
                        report_mismatch("last_pixel", m_tlast, want.last);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                stall_left = (rx_steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int useful;
        int tally;
        int phase;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed lines under the reset frame of 1000 by 640.
        push_advances(1);
        push_start(0, 0, 0, 0, 32'h0000_0000);
        push_advances(1);
        push_start(999, 639, 999, 639, 32'hFFFF_FFFF);
        push_start(1000, 640, 1000, 640, 32'h8000_0001);
        push_start(-8192, -8192, 8191, 8191, 32'h1234_5678);
        push_advances(1);
        push_start(8191, -8192, -8192, 8191, 32'hA5A5_5A5A);
        push_advances(1);
        push_start(998, 3, 1001, 5, 32'h00FF_00FF);
        push_advances(3);
        push_start(2, -1, 0, 3, 32'hFF00_FF00);
        push_advances(4);
        push_start(3, 3, 0, 3, 32'h0F0F_0F0F);
        push_advances(3);
        push_start(7, 2, 7, 0, 32'hF0F0_F0F0);
        push_advances(3);
        wait_idle();

        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: set_frame(1, 1);
                1: set_frame(4096, 4096);
                2: set_frame(8191, 0);
                3: set_frame($urandom_range(1, 300), $urandom_range(1, 300));
                default: set_frame(640, 480);
            endcase
            tx_steady = $urandom_range(0, 3) == 0;
            rx_steady = $urandom_range(0, 3) == 0;
            tally = 0;
            while (tally < PHASE_ITEMS)
            begin
                queue_random_line(useful);
                tally += useful;
            end
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
